// ===== sv/mbg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mbg_pkg;

    // default geometry and stack size
    localparam int MAX_COLS_DEF    = 128;
    localparam int MAX_ROWS_DEF    = 64;
    localparam int STACK_DEPTH_DEF = 2048;

    // fixed field widths
    localparam int OP_W      = 2;
    localparam int RAND_W    = 8;
    localparam int CELL_X_W  = 7;
    localparam int CELL_Y_W  = 6;
    localparam int COLS_W    = 8;
    localparam int ROWS_W    = 7;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 8;
    localparam int IN_DATA_W  = 24;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 16;

    // register reset values
    localparam logic [COLS_W-1:0] MAZE_COLS_RST = 8'd79;
    localparam logic [ROWS_W-1:0] MAZE_ROWS_RST = 7'd23;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAZE_COLS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAZE_ROWS = 1'd1;

    // op codes
    localparam logic [OP_W-1:0] OP_START    = 2'd0;
    localparam logic [OP_W-1:0] OP_CONTINUE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ     = 2'd2;

    // direction codes
    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_RIGHT = 2'd1;
    localparam logic [1:0] DIR_DOWN  = 2'd2;
    localparam logic [1:0] DIR_LEFT  = 2'd3;

    typedef struct packed {
        logic [COLS_W-1:0] maze_cols;
        logic [ROWS_W-1:0] maze_rows;
    } cfg_t;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [RAND_W-1:0]   rand_bits;
        logic [CELL_X_W-1:0] cell_x;
        logic [CELL_Y_W-1:0] cell_y;
    } item_t;

    typedef struct packed {
        logic [CELL_X_W-1:0] out_x;
        logic [CELL_Y_W-1:0] out_y;
        logic                is_open;
        logic                finished;
    } result_t;

    // four swaps of the identity order, entry i with entry bits[2i+1:2i]
    function automatic logic [7:0] shuffle_dirs(input logic [RAND_W-1:0] bits);
        logic [1:0] d [4];
        logic [1:0] r;
        logic [1:0] t;
        logic [7:0] order;
        for (int i = 0; i < 4; i++)
        begin
            d[i] = 2'(i);
        end
        for (int i = 0; i < 4; i++)
        begin
            r    = bits[2*i +: 2];
            t    = d[r];
            d[r] = d[i];
            d[i] = t;
        end
        for (int i = 0; i < 4; i++)
        begin
            order[2*i +: 2] = d[i];
        end
        return order;
    endfunction

endpackage

`default_nettype wire

// ===== sv/mbg_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mbg_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/mbg_walker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mbg_walker #(
    parameter int MAX_COLS    = mbg_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS    = mbg_pkg::MAX_ROWS_DEF,
    parameter int STACK_DEPTH = mbg_pkg::STACK_DEPTH_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire mbg_pkg::cfg_t   cfg,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire mbg_pkg::item_t  in_item,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output mbg_pkg::result_t     out_res
);

    localparam int XW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int YW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    // probe coordinates carry a sign bit and headroom past the bounds
    localparam int XS    = ((XW > mbg_pkg::COLS_W) ? XW : mbg_pkg::COLS_W) + 2;
    localparam int YS    = ((YW > mbg_pkg::ROWS_W) ? YW : mbg_pkg::ROWS_W) + 2;
    localparam int CELLS = MAX_COLS * MAX_ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int SW    = $clog2(STACK_DEPTH);
    localparam int LW    = $clog2(STACK_DEPTH + 1);

    typedef struct packed {
        logic [XW-1:0] x;
        logic [YW-1:0] y;
        logic [7:0]    order;
        logic [2:0]    dir_idx;
    } frame_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_START,
        S_READ,
        S_READ2,
        S_PROBE,
        S_POPWAIT,
        S_MAPRD,
        S_OPEN_CELL,
        S_DONE
    } state_t;

    function automatic logic in_maze(input logic [XS-1:0] x, input logic [YS-1:0] y,
                                     input mbg_pkg::cfg_t c);
        return !x[XS-1] && !y[YS-1]
            && (x < XS'(c.maze_cols)) && (x < XS'(MAX_COLS))
            && (y < YS'(c.maze_rows)) && (y < YS'(MAX_ROWS));
    endfunction

    function automatic logic [AW-1:0] cell_addr(input logic [XW-1:0] x,
                                                input logic [YW-1:0] y);
        return AW'(AW'(y) * AW'(MAX_COLS)) + AW'(x);
    endfunction

    state_t           state_reg, state_next;
    logic [AW-1:0]    clr_addr_reg, clr_addr_next;
    logic             clr_start_reg, clr_start_next;
    logic [LW-1:0]    level_reg, level_next;
    logic             active_reg, active_next;
    frame_t           top_reg, top_next;
    mbg_pkg::item_t   item_reg, item_next;
    mbg_pkg::result_t res_reg, res_next;
    mbg_pkg::result_t out_reg, out_next;
    logic             out_valid_reg, out_valid_next;
    logic [XW-1:0]    cx_reg, cx_next;
    logic [YW-1:0]    cy_reg, cy_next;
    logic [XW-1:0]    mx_reg, mx_next;
    logic [YW-1:0]    my_reg, my_next;
    logic             inb_reg, inb_next;

    logic             map_we, map_re, map_wdata;
    logic [AW-1:0]    map_waddr, map_raddr;
    logic             map_rdata;
    logic             stk_we, stk_re;
    logic [SW-1:0]    stk_waddr, stk_raddr;
    frame_t           stk_wdata, stk_rdata;

    logic [XS-1:0]    px, pmx, ix;
    logic [YS-1:0]    py, pmy, iy;
    logic [LW-1:0]    lvl_m1, lvl_m2;
    logic             out_free;

    mbg_ram #(
        .WIDTH (1),
        .DEPTH (CELLS)
    ) u_map (
        .clk   (clk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .re    (map_re),
        .raddr (map_raddr),
        .rdata (map_rdata)
    );

    mbg_ram #(
        .WIDTH ($bits(frame_t)),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .re    (stk_re),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;
    assign out_free  = !out_valid_reg || out_ready;
    assign lvl_m1    = level_reg - LW'(1);
    assign lvl_m2    = level_reg - LW'(2);
    assign ix        = XS'(item_reg.cell_x);
    assign iy        = YS'(item_reg.cell_y);

    // neighbor two steps away and the wall cell between, in the frame's next direction
    always_comb
    begin
        px  = XS'(top_reg.x);
        py  = YS'(top_reg.y);
        pmx = XS'(top_reg.x);
        pmy = YS'(top_reg.y);
        unique case (top_reg.order[2*top_reg.dir_idx[1:0] +: 2])
            mbg_pkg::DIR_UP:
            begin
                py  = YS'(top_reg.y) - YS'(2);
                pmy = YS'(top_reg.y) - YS'(1);
            end
            mbg_pkg::DIR_RIGHT:
            begin
                px  = XS'(top_reg.x) + XS'(2);
                pmx = XS'(top_reg.x) + XS'(1);
            end
            mbg_pkg::DIR_DOWN:
            begin
                py  = YS'(top_reg.y) + YS'(2);
                pmy = YS'(top_reg.y) + YS'(1);
            end
            mbg_pkg::DIR_LEFT:
            begin
                px  = XS'(top_reg.x) - XS'(2);
                pmx = XS'(top_reg.x) - XS'(1);
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        clr_start_next = clr_start_reg;
        level_next     = level_reg;
        active_next    = active_reg;
        top_next       = top_reg;
        item_next      = item_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        mx_next        = mx_reg;
        my_next        = my_reg;
        inb_next       = inb_reg;

        map_we    = 1'b0;
        map_waddr = clr_addr_reg;
        map_wdata = 1'b0;
        map_re    = 1'b0;
        map_raddr = cell_addr(px[XW-1:0], py[YW-1:0]);
        stk_we    = 1'b0;
        stk_waddr = lvl_m1[SW-1:0];
        stk_wdata = top_reg;
        stk_re    = 1'b0;
        stk_raddr = lvl_m2[SW-1:0];

        unique case (state_reg)
            S_CLEAR:
            begin
                map_we        = 1'b1;
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(CELLS - 1))
                begin
                    clr_addr_next = '0;
                    state_next    = clr_start_reg ? S_START : S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    item_next = in_item;
                    res_next  = '0;
                    unique case (in_item.op)
                        mbg_pkg::OP_START:
                        begin
                            level_next     = '0;
                            active_next    = 1'b0;
                            clr_start_next = 1'b1;
                            clr_addr_next  = '0;
                            state_next     = S_CLEAR;
                        end
                        mbg_pkg::OP_CONTINUE:
                        begin
                            if (active_reg)
                            begin
                                state_next = S_PROBE;
                            end
                            else
                            begin
                                res_next.finished = 1'b1;
                                state_next        = S_DONE;
                            end
                        end
                        mbg_pkg::OP_READ:
                        begin
                            state_next = S_READ;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_START:
            begin
                if (in_maze(ix, iy, cfg))
                begin
                    map_we           = 1'b1;
                    map_waddr        = cell_addr(ix[XW-1:0], iy[YW-1:0]);
                    map_wdata        = 1'b1;
                    top_next.x       = ix[XW-1:0];
                    top_next.y       = iy[YW-1:0];
                    top_next.order   = mbg_pkg::shuffle_dirs(item_reg.rand_bits);
                    top_next.dir_idx = '0;
                    level_next       = LW'(1);
                    active_next      = 1'b1;
                    res_next.out_x   = item_reg.cell_x;
                    res_next.out_y   = item_reg.cell_y;
                end
                else
                begin
                    res_next.finished = 1'b1;
                end
                state_next = S_DONE;
            end

            S_READ:
            begin
                inb_next   = in_maze(ix, iy, cfg);
                map_re     = 1'b1;
                map_raddr  = cell_addr(ix[XW-1:0], iy[YW-1:0]);
                state_next = S_READ2;
            end

            S_READ2:
            begin
                res_next.is_open  = map_rdata && inb_reg;
                res_next.finished = !active_reg;
                state_next        = S_DONE;
            end

            S_PROBE:
            begin
                if (level_reg == '0)
                begin
                    active_next       = 1'b0;
                    res_next.finished = 1'b1;
                    state_next        = S_DONE;
                end
                else if (top_reg.dir_idx[2])
                begin
                    // frame exhausted: pop, and reload the frame below from memory if one is left
                    level_next = lvl_m1;
                    if (level_reg >= LW'(2))
                    begin
                        stk_re     = 1'b1;
                        state_next = S_POPWAIT;
                    end
                end
                else
                begin
                    top_next.dir_idx = top_reg.dir_idx + 3'd1;
                    cx_next          = px[XW-1:0];
                    cy_next          = py[YW-1:0];
                    mx_next          = pmx[XW-1:0];
                    my_next          = pmy[YW-1:0];
                    if (in_maze(px, py, cfg))
                    begin
                        map_re     = 1'b1;
                        state_next = S_MAPRD;
                    end
                end
            end

            S_POPWAIT:
            begin
                top_next   = stk_rdata;
                state_next = S_PROBE;
            end

            S_MAPRD:
            begin
                if (!map_rdata)
                begin
                    map_we     = 1'b1;
                    map_waddr  = cell_addr(mx_reg, my_reg);
                    map_wdata  = 1'b1;
                    state_next = S_OPEN_CELL;
                end
                else
                begin
                    state_next = S_PROBE;
                end
            end

            S_OPEN_CELL:
            begin
                map_we    = 1'b1;
                map_waddr = cell_addr(cx_reg, cy_reg);
                map_wdata = 1'b1;
                // spill the current top below the new frame unless the stack is full
                if (level_reg < LW'(STACK_DEPTH))
                begin
                    stk_we           = 1'b1;
                    top_next.x       = cx_reg;
                    top_next.y       = cy_reg;
                    top_next.order   = mbg_pkg::shuffle_dirs(item_reg.rand_bits);
                    top_next.dir_idx = '0;
                    level_next       = level_reg + LW'(1);
                end
                res_next.out_x = mbg_pkg::CELL_X_W'(cx_reg);
                res_next.out_y = mbg_pkg::CELL_Y_W'(cy_reg);
                state_next     = S_DONE;
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            clr_start_reg <= 1'b0;
            level_reg     <= '0;
            active_reg    <= 1'b0;
            top_reg       <= '0;
            item_reg      <= '0;
            res_reg       <= '0;
            out_reg       <= '0;
            out_valid_reg <= 1'b0;
            cx_reg        <= '0;
            cy_reg        <= '0;
            mx_reg        <= '0;
            my_reg        <= '0;
            inb_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            clr_start_reg <= clr_start_next;
            level_reg     <= level_next;
            active_reg    <= active_next;
            top_reg       <= top_next;
            item_reg      <= item_next;
            res_reg       <= res_next;
            out_reg       <= out_next;
            out_valid_reg <= out_valid_next;
            cx_reg        <= cx_next;
            cy_reg        <= cy_next;
            mx_reg        <= mx_next;
            my_reg        <= my_next;
            inb_reg       <= inb_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/maze_backtracker_generator.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Recursive-backtracker maze carver. The grid bitmap (MAX_COLS*MAX_ROWS cells, one bit
// each) and the walk stack (STACK_DEPTH frames) live in two RAMs with registered reads;
// the top frame is cached in registers. After reset the block sweeps the bitmap to walls,
// one cell a cycle, with s_tready low; config writes are taken during the sweep. Op start
// repeats that sweep and then opens the start cell if it lies in the maze. Op continue
// tries the directions of the top frame in its shuffled order, reading the target cell
// when it is in bounds, and pops exhausted frames, so its length follows the shape of the
// maze. Op read reads one cell of the bitmap; continue on an idle walk and an unused op go
// straight to the output. One item is in work at a time; a finished word waits in the
// output register while the next item is accepted. Config may only be written while no
// item is in work.
module maze_backtracker_generator #(
    parameter int MAX_COLS    = mbg_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS    = mbg_pkg::MAX_ROWS_DEF,
    parameter int STACK_DEPTH = mbg_pkg::STACK_DEPTH_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // rand_bits[7:0], cell_x[14:8], cell_y[20:15], zero fill
    input  wire logic [mbg_pkg::IN_DATA_W-1:0]     s_tdata,
    // op[1:0]
    input  wire logic [mbg_pkg::IN_USER_W-1:0]     s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // out_x[6:0], out_y[12:7], is_open[13], zero fill
    output logic      [mbg_pkg::OUT_DATA_W-1:0]    m_tdata,
    // finished
    output logic                                   m_tlast,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [mbg_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  wire logic [mbg_pkg::CFG_DAT_W-1:0]     cfg_data
);

    mbg_pkg::cfg_t    cfg_reg, cfg_next;
    mbg_pkg::item_t   item;
    mbg_pkg::result_t res;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_addr)
                mbg_pkg::REG_MAZE_COLS: cfg_next.maze_cols = cfg_data;
                mbg_pkg::REG_MAZE_ROWS: cfg_next.maze_rows = cfg_data[mbg_pkg::ROWS_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.maze_cols <= mbg_pkg::MAZE_COLS_RST;
            cfg_reg.maze_rows <= mbg_pkg::MAZE_ROWS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign item.op        = s_tuser;
    assign item.rand_bits = s_tdata[7:0];
    assign item.cell_x    = s_tdata[14:8];
    assign item.cell_y    = s_tdata[20:15];

    mbg_walker #(
        .MAX_COLS    (MAX_COLS),
        .MAX_ROWS    (MAX_ROWS),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_walker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    assign m_tdata = {2'b00, res.is_open, res.out_y, res.out_x};
    assign m_tlast = res.finished;

endmodule

`default_nettype wire
